FILE: design/multi_pattern_byte_trap_top_assert.svh
// assertion macros for the byte trap block
`ifndef MULTI_PATTERN_BYTE_TRAP_TOP_ASSERT_SVH
`define MULTI_PATTERN_BYTE_TRAP_TOP_ASSERT_SVH
// implication checked every cycle outside reset
`define MPBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MPBT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: design/mpbt_pkg.sv
// shared types and constants of the byte trap block
package mpbt_pkg;
  localparam int MAX_TRAPS_DEF    = 16;
  localparam int MAX_CODE_LEN_DEF = 8;

  typedef enum logic [2:0] {
    OP_SCAN    = 3'd0,
    OP_ADD     = 3'd1,
    OP_RM_ID   = 3'd2,
    OP_RM_CODE = 3'd3,
    OP_RM_BOTH = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DUP,
    ST_REMOVE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic remove;
    logic clear;
    logic append;
    logic emit_step;
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    logic dup_found;
    logic hits_any;
    logic hits_more;
    logic walk_done;
  } sts_t;
endpackage

FILE: design/mpbt_ctrl.sv
// controller sequencing scan, add, removal and hit emission
module mpbt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_operation,
  output logic                out_valid,
  input  logic                out_ready,
  input  mpbt_pkg::sts_t      sts,
  output mpbt_pkg::cmd_t      cmd
);
  mpbt_pkg::state_t state_r, state_nxt;
  logic acc;

  assign acc = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpbt_pkg::ST_IDLE: begin
        if (acc) begin
          priority if (in_operation == mpbt_pkg::OP_SCAN) state_nxt = mpbt_pkg::ST_SCAN;
          else if (in_operation == mpbt_pkg::OP_ADD) state_nxt = mpbt_pkg::ST_DUP;
          else if (in_operation == mpbt_pkg::OP_RM_ID || in_operation == mpbt_pkg::OP_RM_CODE
                   || in_operation == mpbt_pkg::OP_RM_BOTH) state_nxt = mpbt_pkg::ST_REMOVE;
          else state_nxt = mpbt_pkg::ST_IDLE;
        end
      end
      mpbt_pkg::ST_SCAN:   state_nxt = sts.hits_any ? mpbt_pkg::ST_EMIT : mpbt_pkg::ST_IDLE;
      mpbt_pkg::ST_DUP:    state_nxt = mpbt_pkg::ST_IDLE;
      mpbt_pkg::ST_REMOVE: state_nxt = sts.walk_done ? mpbt_pkg::ST_IDLE : mpbt_pkg::ST_REMOVE;
      mpbt_pkg::ST_EMIT: begin
        if (out_ready && !sts.hits_more) state_nxt = mpbt_pkg::ST_IDLE;
      end
      default: state_nxt = mpbt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      mpbt_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = acc;
        cmd.clear = acc && (in_operation == mpbt_pkg::OP_CLEAR);
      end
      mpbt_pkg::ST_SCAN:   cmd.scan = 1'b1;
      mpbt_pkg::ST_DUP:    cmd.append = !sts.dup_found;
      mpbt_pkg::ST_REMOVE: cmd.remove = 1'b1;
      mpbt_pkg::ST_EMIT: begin
        cmd.out_valid = 1'b1;
        cmd.emit_step = out_ready;
      end
      default: ;
    endcase
  end

  assign out_valid = cmd.out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mpbt_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

`include "multi_pattern_byte_trap_top_assert.svh"
  `MPBT_ASSERT_IMP(a_ready_idle, in_ready, state_r == mpbt_pkg::ST_IDLE, "ready outside idle")
  `MPBT_ASSERT_IMP(a_out_no_in, out_valid, !in_ready, "output and input overlap")
  `MPBT_ASSERT_NXT(a_scan_next, state_r == mpbt_pkg::ST_SCAN && !sts.hits_any,
                   state_r == mpbt_pkg::ST_IDLE, "scan without hits did not finish")
endmodule

FILE: design/mpbt_dp.sv
// trap table, parallel byte compare, compaction and hit queue
module mpbt_dp #(
  parameter int MAX_TRAPS    = mpbt_pkg::MAX_TRAPS_DEF,
  parameter int MAX_CODE_LEN = mpbt_pkg::MAX_CODE_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mpbt_pkg::cmd_t  cmd,
  output mpbt_pkg::sts_t  sts,
  input  logic [2:0]      in_operation,
  input  logic [7:0]      in_data_byte,
  input  logic [15:0]     in_trap_id,
  input  logic [63:0]     in_code_bytes,
  input  logic [3:0]      in_code_length,
  output logic [15:0]     out_trapped_id,
  output logic            out_last
);
  localparam int IW = (MAX_TRAPS > 1) ? $clog2(MAX_TRAPS) : 1;
  localparam int CW = $clog2(MAX_TRAPS + 1);

  logic [2:0]  op_r;
  logic [7:0]  byte_r;
  logic [15:0] id_r;
  logic [63:0] code_r;
  logic [3:0]  len_r;
  logic [63:0] mask;
  logic        len_ok;

  logic [15:0] e_id_r   [MAX_TRAPS];
  logic [63:0] e_code_r [MAX_TRAPS];
  logic [3:0]  e_len_r  [MAX_TRAPS];
  logic [2:0]  e_pos_r  [MAX_TRAPS];
  logic [CW-1:0] count_r;
  logic [MAX_TRAPS-1:0] hit_r, hit_nxt, dup_vec;
  logic [IW:0] rd_r, wr_r;

  assign len_ok = len_r >= 4'd1 && {28'd0, len_r} <= 32'(MAX_CODE_LEN);

  always_comb begin
    for (int b = 0; b < 8; b++) mask[b*8 +: 8] = (4'(b) < len_r) ? 8'hFF : 8'h00;
  end

  always_comb begin
    for (int i = 0; i < MAX_TRAPS; i++) begin
      dup_vec[i] = (32'(i) < 32'(count_r)) && e_len_r[i] == len_r && e_id_r[i] == id_r
                   && e_code_r[i] == (code_r & mask);
    end
  end

  logic [IW-1:0] rd_i, first_i;
  logic          rm_id_hit, rm_code_hit, rm_drop;
  assign rd_i = rd_r[IW-1:0];
  assign rm_id_hit   = e_id_r[rd_i] == id_r;
  assign rm_code_hit = len_ok && e_len_r[rd_i] == len_r
                       && ((e_code_r[rd_i] ^ code_r) & mask) == 64'd0;
  always_comb begin
    unique case (op_r)
      mpbt_pkg::OP_RM_ID:   rm_drop = rm_id_hit;
      mpbt_pkg::OP_RM_CODE: rm_drop = rm_code_hit;
      default:              rm_drop = rm_id_hit && rm_code_hit;
    endcase
  end

  always_comb begin
    first_i = '0;
    for (int i = MAX_TRAPS - 1; i >= 0; i--) if (hit_r[i]) first_i = IW'(i);
  end

  always_comb begin
    hit_nxt = '0;
    for (int i = 0; i < MAX_TRAPS; i++) begin
      hit_nxt[i] = (32'(i) < 32'(count_r)) && e_code_r[i][{e_pos_r[i], 3'b000} +: 8] == byte_r
                   && ({1'b0, e_pos_r[i]} + 4'd1 >= e_len_r[i]);
    end
  end

  assign sts.dup_found = !len_ok || (|dup_vec) || 32'(count_r) >= 32'(MAX_TRAPS);
  assign sts.hits_any  = |hit_nxt;
  assign sts.hits_more = $countones(hit_r) > 1;
  assign sts.walk_done = 32'(rd_r) + 1 >= 32'(count_r) || 32'(count_r) == 0;
  assign out_trapped_id = e_id_r[first_i];
  assign out_last = $countones(hit_r) == 1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation; byte_r <= in_data_byte; id_r <= in_trap_id;
      code_r <= in_code_bytes; len_r <= in_code_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; hit_r <= '0; rd_r <= '0; wr_r <= '0;
      for (int i = 0; i < MAX_TRAPS; i++) e_pos_r[i] <= '0;
    end else begin
      if (cmd.load) begin rd_r <= '0; wr_r <= '0; end
      if (cmd.clear) count_r <= '0;
      if (cmd.scan) begin
        hit_r <= hit_nxt;
        for (int i = 0; i < MAX_TRAPS; i++) begin
          if (e_code_r[i][{e_pos_r[i], 3'b000} +: 8] == byte_r && !hit_nxt[i])
            e_pos_r[i] <= e_pos_r[i] + 3'd1;
          else e_pos_r[i] <= '0;
        end
      end
      if (cmd.emit_step) hit_r[first_i] <= 1'b0;
      if (cmd.append) begin
        e_id_r[count_r[IW-1:0]]   <= id_r;
        e_code_r[count_r[IW-1:0]] <= code_r & mask;
        e_len_r[count_r[IW-1:0]]  <= len_r;
        e_pos_r[count_r[IW-1:0]]  <= '0;
        count_r <= count_r + 1'b1;
      end
      if (cmd.remove) begin
        if (32'(count_r) != 0) begin
          if (!rm_drop) begin
            e_id_r[wr_r[IW-1:0]]   <= e_id_r[rd_i];
            e_code_r[wr_r[IW-1:0]] <= e_code_r[rd_i];
            e_len_r[wr_r[IW-1:0]]  <= e_len_r[rd_i];
            e_pos_r[wr_r[IW-1:0]]  <= e_pos_r[rd_i];
            wr_r <= wr_r + 1'b1;
          end
          rd_r <= rd_r + 1'b1;
          if (sts.walk_done) count_r <= CW'(wr_r) + CW'(!rm_drop);
        end
      end
    end
  end

`include "multi_pattern_byte_trap_top_assert.svh"
  `MPBT_ASSERT_IMP(a_count_max, 1'b1, 32'(count_r) <= 32'(MAX_TRAPS), "table over full")
  `MPBT_ASSERT_IMP(a_wr_rd, 1'b1, wr_r <= rd_r, "compaction write passed read")
  `MPBT_ASSERT_NXT(a_append, cmd.append, count_r == $past(count_r) + 1'b1, "append lost")
endmodule

FILE: design/multi_pattern_byte_trap_top.sv
// byte trap top level: holds up to MAX_TRAPS traps of 1 to MAX_CODE_LEN bytes; a scan byte
// emits the ids of its completed traps in table order, the controller being busy until the
// last is taken; a removal walks the stored traps one entry a cycle by the compaction pointer
module multi_pattern_byte_trap_top #(
  parameter int MAX_TRAPS    = mpbt_pkg::MAX_TRAPS_DEF,
  parameter int MAX_CODE_LEN = mpbt_pkg::MAX_CODE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_trap_id,
  input  logic [63:0] in_code_bytes,
  input  logic [3:0]  in_code_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_trapped_id,
  output logic        out_last
);
  mpbt_pkg::cmd_t cmd;
  mpbt_pkg::sts_t sts;

  mpbt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation,
    .out_valid, .out_ready, .sts, .cmd
  );

  mpbt_dp #(.MAX_TRAPS(MAX_TRAPS), .MAX_CODE_LEN(MAX_CODE_LEN)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_operation, .in_data_byte, .in_trap_id,
    .in_code_bytes, .in_code_length, .out_trapped_id, .out_last
  );
endmodule

FILE: tb/tb_multi_pattern_byte_trap_top.sv
// testbench for the byte trap block: random transfers checked against a table predictor
`timescale 1ns / 1ps
module tb_multi_pattern_byte_trap_top;
  localparam int NTRAPS = 16;
  localparam int NCODE = 8;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  data;
    logic [15:0] id;
    logic [63:0] code;
    logic [3:0]  len;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic        last;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_operation = '0;
  logic [7:0] in_data_byte = '0;
  logic [15:0] in_trap_id = '0;
  logic [63:0] in_code_bytes = '0;
  logic [3:0] in_code_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_trapped_id;
  logic out_last;

  multi_pattern_byte_trap_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_data_byte(in_data_byte),
    .in_trap_id(in_trap_id), .in_code_bytes(in_code_bytes),
    .in_code_length(in_code_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_trapped_id(out_trapped_id), .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] tbl_id [NTRAPS];
  logic [63:0] tbl_code [NTRAPS];
  logic [3:0]  tbl_len [NTRAPS];
  int          tbl_pos [NTRAPS];
  int          tbl_count = 0;

  cmd_item_t pending_cmds[$];
  hit_t      expected_hits[$];
  int        errors = 0;
  int        sent = 0;

  logic send_pause = 1'b0;
  logic rx_hold = 1'b0;
  int   rx_hold_cycles = 0;

  function automatic logic [63:0] len_mask(input logic [3:0] len);
    return (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
  endfunction

  function automatic void predict_trap_table(input cmd_item_t c);
    int pos;
    int wr;
    int nhit;
    logic [63:0] m;
    logic len_good;
    logic id_hit;
    logic code_hit;
    logic drop;
    logic [7:0] want;
    len_good = (c.len >= 1) && (c.len <= NCODE);
    m = len_mask(c.len);
    nhit = 0;
    case (c.op)
      mpbt_pkg::OP_SCAN: begin
        for (int i = 0; i < tbl_count; i++) begin
          pos = tbl_pos[i] & 7;
          want = tbl_code[i][8*pos +: 8];
          pos = (c.data == want) ? pos + 1 : 0;
          if (pos >= tbl_len[i]) begin
            pos = 0;
            if (nhit < 16) begin
              expected_hits.insert(expected_hits.size(), hit_t'{tbl_id[i], 1'b0});
              nhit++;
            end
          end
          tbl_pos[i] = pos;
        end
        if (nhit > 0) expected_hits[expected_hits.size() - 1].last = 1'b1;
      end
      mpbt_pkg::OP_ADD: begin
        if (len_good) begin
          drop = 1'b0;
          for (int i = 0; i < tbl_count; i++)
            if (tbl_len[i] == c.len && tbl_id[i] == c.id && tbl_code[i] == (c.code & m))
              drop = 1'b1;
          if (!drop && tbl_count < NTRAPS) begin
            tbl_id[tbl_count] = c.id;
            tbl_code[tbl_count] = c.code & m;
            tbl_len[tbl_count] = c.len;
            tbl_pos[tbl_count] = 0;
            tbl_count++;
          end
        end
      end
      mpbt_pkg::OP_RM_ID, mpbt_pkg::OP_RM_CODE, mpbt_pkg::OP_RM_BOTH: begin
        wr = 0;
        for (int i = 0; i < tbl_count; i++) begin
          id_hit = tbl_id[i] == c.id;
          code_hit = len_good && tbl_len[i] == c.len && ((tbl_code[i] ^ c.code) & m) == 0;
          drop = (c.op == mpbt_pkg::OP_RM_ID) ? id_hit
                 : (c.op == mpbt_pkg::OP_RM_CODE) ? code_hit : (id_hit && code_hit);
          if (!drop) begin
            tbl_id[wr] = tbl_id[i];
            tbl_code[wr] = tbl_code[i];
            tbl_len[wr] = tbl_len[i];
            tbl_pos[wr] = tbl_pos[i];
            wr++;
          end
        end
        tbl_count = wr;
      end
      mpbt_pkg::OP_CLEAR: tbl_count = 0;
      default: ;
    endcase
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 6) ? 0 :
           ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // sampled handshakes at the rising edge
  logic in_ready_q = 1'b0;
  always @(posedge clk) begin
    in_ready_q <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      predict_trap_table(cmd_item_t'{in_operation, in_data_byte, in_trap_id, in_code_bytes,
                                     in_code_length});
      sent <= sent + 1;
    end
  end

  // driver
  int tx_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready_q) begin
        if (tx_gap > 0 || send_pause || pending_cmds.size() == 0) begin
          in_valid <= 1'b0;
          if (tx_gap > 0) tx_gap <= tx_gap - 1;
        end else begin
          cmd_item_t c;
          c = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_operation <= c.op;
          in_data_byte <= c.data;
          in_trap_id <= c.id;
          in_code_bytes <= c.code;
          in_code_length <= c.len;
          tx_gap <= gap_len();
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        $error("unexpected transfer: trapped_id %h last %b", out_trapped_id, out_last);
        errors++;
      end else begin
        hit_t e;
        e = expected_hits.pop_front();
        if (out_trapped_id !== e.id) begin
          $error("trapped_id expected %h actual %h", e.id, out_trapped_id);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("last expected %b actual %b", e.last, out_last);
          errors++;
        end
      end
    end
  end

  // receiver stall
  int rx_gap = 0;
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles <= rx_hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (rx_hold) begin
      rx_hold_cycles <= 300;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      rx_gap <= gap_len();
    end
  end

  function automatic cmd_item_t mk(input logic [2:0] op, input logic [7:0] d,
                                   input logic [15:0] id, input logic [63:0] code,
                                   input logic [3:0] len);
    return '{op, d, id, code, len};
  endfunction

  function automatic void enqueue(input cmd_item_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic logic [63:0] rand_code();
    return {$urandom(), $urandom()};
  endfunction

  // small alphabet so scans complete traps often
  function automatic logic [7:0] alpha();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
  endfunction

  function automatic logic [63:0] alpha_code();
    logic [63:0] c;
    for (int i = 0; i < 8; i++) c[8*i +: 8] = alpha();
    return c;
  endfunction

  task automatic drain();
    wait (pending_cmds.size() == 0 && !in_valid && expected_hits.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    logic [63:0] c;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed
    enqueue(mk(mpbt_pkg::OP_SCAN, 8'h00, 16'h0, 64'h0, 4'd1));
    enqueue(mk(mpbt_pkg::OP_ADD, 8'h00, 16'hFFFF, 64'h0, 4'd1));
    enqueue(mk(mpbt_pkg::OP_ADD, 8'h00, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8));
    enqueue(mk(mpbt_pkg::OP_ADD, 8'h00, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8));
    enqueue(mk(mpbt_pkg::OP_ADD, 8'h00, 16'h1234, 64'h0000_0000_0000_0041, 4'd0));
    enqueue(mk(mpbt_pkg::OP_ADD, 8'h00, 16'h1234, 64'h0, 4'd15));
    enqueue(mk(mpbt_pkg::OP_ADD, 8'h00, 16'h0042, 64'hAA00_0041, 4'd2));
    enqueue(mk(mpbt_pkg::OP_SCAN, 8'h00, 16'h0, 64'h0, 4'd0));
    enqueue(mk(mpbt_pkg::OP_SCAN, 8'h41, 16'h0, 64'h0, 4'd0));
    enqueue(mk(mpbt_pkg::OP_SCAN, 8'h00, 16'h0, 64'h0, 4'd0));
    for (int i = 0; i < 8; i++)
      enqueue(mk(mpbt_pkg::OP_SCAN, 8'hFF, 16'h0, 64'h0, 4'd0));
    enqueue(mk(3'd6, 8'hFF, 16'hFFFF, '1, 4'd1));
    enqueue(mk(3'd7, 8'h00, 16'hFFFF, '1, 4'd1));
    enqueue(mk(mpbt_pkg::OP_RM_CODE, 8'h00, 16'h0, 64'h41, 4'd0));
    enqueue(mk(mpbt_pkg::OP_RM_BOTH, 8'h00, 16'h0042, 64'h1234_0000_0041, 4'd2));
    enqueue(mk(mpbt_pkg::OP_RM_ID, 8'h00, 16'hFFFF, 64'h0, 4'd1));
    enqueue(mk(mpbt_pkg::OP_CLEAR, 8'h00, 16'h0, 64'h0, 4'd0));
    drain();

    // full table, all hit the same byte, then overflow add
    for (int i = 0; i < 17; i++)
      enqueue(mk(mpbt_pkg::OP_ADD, 8'h00, 16'(i * 4099), 64'h5A, 4'd1));
    for (int i = 0; i < 6; i++)
      enqueue(mk(mpbt_pkg::OP_SCAN, 8'h5A, 16'h0, 64'h0, 4'd0));
    // sender pauses until every expected result has come
    wait (pending_cmds.size() == 0);
    send_pause = 1'b1;
    for (int i = 0; i < 4; i++)
      enqueue(mk(mpbt_pkg::OP_SCAN, 8'h5A, 16'h0, 64'h0, 4'd0));
    wait (!in_valid && expected_hits.size() == 0);
    repeat (5) @(posedge clk);
    send_pause = 1'b0;
    drain();
    // long receiver hold with the sender still offering
    rx_hold = 1'b1;
    wait (rx_hold_cycles > 0);
    rx_hold = 1'b0;
    for (int i = 0; i < 8; i++)
      enqueue(mk(mpbt_pkg::OP_SCAN, 8'h5A, 16'h0, 64'h0, 4'd0));
    drain();
    enqueue(mk(mpbt_pkg::OP_CLEAR, 8'h00, 16'h0, 64'h0, 4'd0));

    // random
    for (int n = 0; n < 410; n++) begin
      int r;
      logic [3:0] len;
      r = $urandom_range(0, 99);
      len = (r % 10 == 0) ? 4'($urandom()) : 4'($urandom_range(1, 4));
      c = (r % 7 == 0) ? rand_code() : alpha_code();
      if (r < 60)
        enqueue(mk(mpbt_pkg::OP_SCAN, alpha(), 16'($urandom()), rand_code(),
                   4'($urandom())));
      else if (r < 80)
        enqueue(mk(mpbt_pkg::OP_ADD, 8'($urandom()),
                   16'($urandom_range(0, 7)) ^ {1'($urandom_range(0, 1)), 15'd0},
                   c, len));
      else if (r < 86)
        enqueue(mk(mpbt_pkg::OP_RM_ID, 8'h00, 16'($urandom_range(0, 7)), c, len));
      else if (r < 91)
        enqueue(mk(mpbt_pkg::OP_RM_CODE, 8'h00, 16'($urandom()), c, len));
      else if (r < 96)
        enqueue(mk(mpbt_pkg::OP_RM_BOTH, 8'h00, 16'($urandom_range(0, 7)), c, len));
      else if (r < 98)
        enqueue(mk(mpbt_pkg::OP_CLEAR, 8'h00, 16'h0, 64'h0, 4'd0));
      else
        enqueue(mk(3'($urandom_range(6, 7)), 8'($urandom()),
                   16'($urandom()), rand_code(), 4'($urandom())));
    end
    drain();
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("tb_multi_pattern_byte_trap_top passed");
    end else begin
      $display("tb_multi_pattern_byte_trap_top failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_multi_pattern_byte_trap_top failed");
    $finish;
  end
endmodule
